[rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, register indexes and types for the escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 58;
	localparam int ITER_BITS    = 16;

	localparam int WORD_BITS    = 64;
	localparam int UWORD_BITS   = 63;
	localparam int HALF_BITS    = WORD_BITS / 2;
	localparam int PART_BITS    = HALF_BITS + 1;
	localparam int PROD_BITS    = 2 * PART_BITS;
	localparam int ACC_BITS     = 2 * WORD_BITS;
	localparam int STEP_BITS    = 2;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_REAL   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_IMAG   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_STEP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQ  = 3'd4;

	// -8.0, -4.0, 2^-8, 256, 4.0
	localparam logic [WORD_BITS-1:0]  RST_MIN_REAL   = 64'hE000_0000_0000_0000;
	localparam logic [WORD_BITS-1:0]  RST_MIN_IMAG   = 64'hF000_0000_0000_0000;
	localparam logic [UWORD_BITS-1:0] RST_PIXEL_STEP = 63'h0004_0000_0000_0000;
	localparam logic [ITER_BITS-1:0]  RST_MAX_ITER   = ITER_BITS'(256);
	localparam logic [UWORD_BITS-1:0] RST_RADIUS_SQ  = 63'h1000_0000_0000_0000;

	// partial-product shift codes (multiples of HALF_BITS)
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_HALF = 2'd1;
	localparam logic [1:0] SH_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_ORIGIN,
		ST_CHECK,
		ST_MUL,
		ST_ACC,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]  min_real;
		logic [WORD_BITS-1:0]  min_imag;
		logic [UWORD_BITS-1:0] pixel_step;
		logic [ITER_BITS-1:0]  max_iter;
		logic [UWORD_BITS-1:0] radius_sq;
	} cfg_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_clr;
	} mac_cmd_t;

	typedef struct packed {
		logic                 load;
		logic                 map_mul;
		logic                 map_add;
		mac_cmd_t             mac;
		logic [STEP_BITS-1:0] step;
		logic                 eval;
	} cmd_t;

	typedef struct packed {
		logic cap_reached;
		logic escape;
	} sts_t;

endpackage

[rtl/mbe_mac.sv]
// ----------------------------------------------------------------------------
// mbe_mac
// Signed 64x64 multiply-accumulate over four 33x33 partial products,
// one per cycle, with the product registered before the 128-bit add.
// ----------------------------------------------------------------------------
module mbe_mac (
	input  logic                                    clk,
	input  logic [mbe_pkg::WORD_BITS-1:0]           a,
	input  logic [mbe_pkg::WORD_BITS-1:0]           b,
	input  logic [mbe_pkg::STEP_BITS-1:0]           step,
	input  mbe_pkg::mac_cmd_t                       cmd,
	output logic signed [mbe_pkg::ACC_BITS-1:0]     acc
);
	import mbe_pkg::*;

	logic signed [PART_BITS-1:0] a_part, b_part;
	logic signed [PROD_BITS-1:0] prod_q;
	logic [1:0]                  sh_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  ext;
	logic signed [ACC_BITS-1:0]  term;

	// low halves are unsigned, high halves carry the sign
	always_comb begin
		if (step[1]) begin
			a_part = signed'({a[WORD_BITS-1], a[WORD_BITS-1:HALF_BITS]});
		end else begin
			a_part = signed'({1'b0, a[HALF_BITS-1:0]});
		end
		if (step[0]) begin
			b_part = signed'({b[WORD_BITS-1], b[WORD_BITS-1:HALF_BITS]});
		end else begin
			b_part = signed'({1'b0, b[HALF_BITS-1:0]});
		end
	end

	assign ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

	always_comb begin
		unique case (sh_q)
			SH_NONE: term = ext;
			SH_HALF: term = ext <<< HALF_BITS;
			SH_FULL: term = ext <<< WORD_BITS;
			default: term = ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= a_part * b_part;
			sh_q   <= 2'({1'b0, step[1]} + {1'b0, step[0]});
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + term;
		end
	end

	assign acc = acc_q;

endmodule

[rtl/mbe_regs.sv]
// ----------------------------------------------------------------------------
// mbe_regs
// Configuration register file: plane origin, pixel pitch, iteration cap
// and squared escape radius.
// ----------------------------------------------------------------------------
module mbe_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mbe_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mbe_pkg::WORD_BITS-1:0]        cfg_wdata,
	output mbe_pkg::cfg_t                        cfg
);
	import mbe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_real   <= RST_MIN_REAL;
			cfg_q.min_imag   <= RST_MIN_IMAG;
			cfg_q.pixel_step <= RST_PIXEL_STEP;
			cfg_q.max_iter   <= RST_MAX_ITER;
			cfg_q.radius_sq  <= RST_RADIUS_SQ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_REAL:   cfg_q.min_real   <= cfg_wdata;
				REG_MIN_IMAG:   cfg_q.min_imag   <= cfg_wdata;
				REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_wdata[UWORD_BITS-1:0];
				REG_MAX_ITER:   cfg_q.max_iter   <= cfg_wdata[ITER_BITS-1:0];
				REG_RADIUS_SQ:  cfg_q.radius_sq  <= cfg_wdata[UWORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/mbe_ctrl.sv]
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: maps the pixel, then runs check / four partial products /
// final accumulate / evaluate for each round until escape or cap.
// ----------------------------------------------------------------------------
module mbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mbe_pkg::sts_t sts,
	output mbe_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import mbe_pkg::*;

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.step = step_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map_mul = 1'b1;
				state_d     = ST_ORIGIN;
			end
			ST_ORIGIN: begin
				cmd.map_add = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				step_d = '0;
				if (sts.cap_reached) begin
					state_d = ST_DONE;
				end else begin
					cmd.mac.acc_clr = 1'b1;
					state_d         = ST_MUL;
				end
			end
			ST_MUL: begin
				// accumulate trails the multiply: each product is added in the cycle after it
				cmd.mac.mul_en = 1'b1;
				cmd.mac.acc_en = (step_q != '0);
				step_d         = step_q + 1'b1;
				if (step_q == '1) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.mac.acc_en = 1'b1;
				state_d        = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.escape ? ST_DONE : ST_CHECK;
			end
			ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MAP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/mbe_dpath.sv]
// ----------------------------------------------------------------------------
// mbe_dpath
// Datapath: pixel-to-plane mapping, z and c registers, three MAC lanes
// (zr*zr, zi*zi, zr*zi), escape test and round counter.
// ----------------------------------------------------------------------------
module mbe_dpath (
	input  logic                                clk,
	input  mbe_pkg::cfg_t                       cfg,
	input  mbe_pkg::cmd_t                       cmd,
	input  logic [mbe_pkg::COORD_BITS-1:0]      pixel_x,
	input  logic [mbe_pkg::COORD_BITS-1:0]      pixel_y,
	output mbe_pkg::sts_t                       sts,
	output logic [mbe_pkg::ITER_BITS-1:0]       iterations,
	output logic                                escaped
);
	import mbe_pkg::*;

	localparam int MAP_BITS = COORD_BITS + UWORD_BITS;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [WORD_BITS-1:0]  pm_re_q, pm_im_q;
	logic [WORD_BITS-1:0]  cre_q, cim_q, zr_q, zi_q;
	logic [ITER_BITS-1:0]  it_q;
	logic                  esc_q;

	logic [MAP_BITS-1:0]   map_re, map_im;
	logic [WORD_BITS-1:0]  half;

	logic signed [ACC_BITS-1:0] acc_rr, acc_ii, acc_ri;
	logic [WORD_BITS-1:0]  sr_lo, si_lo, cross_lo, mr, mi, mag;
	logic [WORD_BITS:0]    mag_sum;
	logic                  escape;

	assign map_re = px_q * cfg.pixel_step;
	assign map_im = py_q * cfg.pixel_step;
	assign half   = {2'b00, cfg.pixel_step[UWORD_BITS-1:1]};

	mbe_mac u_mac_rr (
		.clk  (clk),
		.a    (zr_q),
		.b    (zr_q),
		.step (cmd.step),
		.cmd  (cmd.mac),
		.acc  (acc_rr)
	);

	mbe_mac u_mac_ii (
		.clk  (clk),
		.a    (zi_q),
		.b    (zi_q),
		.step (cmd.step),
		.cmd  (cmd.mac),
		.acc  (acc_ii)
	);

	mbe_mac u_mac_ri (
		.clk  (clk),
		.a    (zr_q),
		.b    (zi_q),
		.step (cmd.step),
		.cmd  (cmd.mac),
		.acc  (acc_ri)
	);

	// squares are non-negative, so any bit above the kept word saturates
	assign sr_lo    = acc_rr[FRAC_BITS +: WORD_BITS];
	assign si_lo    = acc_ii[FRAC_BITS +: WORD_BITS];
	assign cross_lo = acc_ri[(FRAC_BITS-1) +: WORD_BITS];
	assign mr       = (|acc_rr[ACC_BITS-1:FRAC_BITS+WORD_BITS]) ? '1 : sr_lo;
	assign mi       = (|acc_ii[ACC_BITS-1:FRAC_BITS+WORD_BITS]) ? '1 : si_lo;
	assign mag_sum  = {1'b0, mr} + {1'b0, mi};
	assign mag      = mag_sum[WORD_BITS] ? '1 : mag_sum[WORD_BITS-1:0];
	assign escape   = mag > {1'b0, cfg.radius_sq};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.map_mul) begin
			pm_re_q <= map_re[WORD_BITS-1:0];
			pm_im_q <= map_im[WORD_BITS-1:0];
		end
		if (cmd.map_add) begin
			cre_q <= cfg.min_real + pm_re_q + half;
			cim_q <= cfg.min_imag + pm_im_q + half;
			zr_q  <= '0;
			zi_q  <= '0;
			it_q  <= '0;
			esc_q <= 1'b0;
		end
		if (cmd.eval) begin
			zr_q  <= sr_lo - si_lo + cre_q;
			zi_q  <= cross_lo + cim_q;
			esc_q <= escape;
			if (!escape) begin
				it_q <= it_q + 1'b1;
			end
		end
	end

	assign sts.cap_reached = (it_q >= cfg.max_iter);
	assign sts.escape      = escape;
	assign iterations      = it_q;
	assign escaped         = esc_q;

endmodule

[rtl/mandelbrot_escape_time_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time evaluator for one pixel in signed Q6.58 fixed point.
//
//   channel   handshake             payload
//   -------   -------------------   -----------------------------------
//   command   start / busy          pixel_x, pixel_y
//   result    done (1-cycle pulse)  iterations, escaped
//   config    cfg_we                cfg_index, cfg_wdata
//
// A pixel runs the map and origin steps, then one round after another until
// escape, or until the check finds the cap reached. In each round the three 64x64
// products are built from four 33x33 partial products per lane, one a cycle.
// Reset loads the default view (-8.0, -4.0, 2^-8, cap 256, radius^2 4.0).
// busy is low in the done cycle, so the next transaction may start there.
// Results cannot be stalled; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [mbe_pkg::COORD_BITS-1:0]      pixel_x,
	input  logic [mbe_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                done,
	output logic [mbe_pkg::ITER_BITS-1:0]       iterations,
	output logic                                escaped,
	input  logic                                cfg_we,
	input  logic [mbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mbe_pkg::WORD_BITS-1:0]       cfg_wdata
);
	import mbe_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	mbe_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mbe_dpath u_dpath (
		.clk        (clk),
		.cfg        (cfg),
		.cmd        (cmd),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.sts        (sts),
		.iterations (iterations),
		.escaped    (escaped)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_escaped_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && escaped |-> iterations < cfg.max_iter)
		else $error("escaped result at or above the iteration cap");

	a_capped_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && !escaped |-> iterations == cfg.max_iter)
		else $error("non-escaped result does not equal the cap");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the escape-time core. A work list of register
// writes and pixel transactions feeds a clocked driver; a clocked monitor
// predicts each accepted pixel with a bit-accurate fixed-point model and
// checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import mbe_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [WORD_BITS-1:0]    Q_ONE        = 64'd1 << FRAC_BITS;

	localparam int SETTLE_CYCLES   = 3;
	localparam int TAIL_CYCLES     = 20;
	localparam int NO_IDLE_FROM    = 700;
	localparam int NO_IDLE_TO      = 1000;
	localparam int RANDOM_VIEWS    = 24;
	localparam int PIXELS_PER_VIEW = 76;
	localparam int MAX_REPORTS     = 50;

	typedef struct {
		bit                      is_write;
		logic [CFG_IDX_BITS-1:0] index;
		logic [WORD_BITS-1:0]    wdata;
		logic [COORD_BITS-1:0]   px;
		logic [COORD_BITS-1:0]   py;
	} work_t;

	typedef struct {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [ITER_BITS-1:0]  iterations;
		logic                  escaped;
	} escape_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    busy;
	logic [COORD_BITS-1:0]   pixel_x   = '0;
	logic [COORD_BITS-1:0]   pixel_y   = '0;
	logic                    done;
	logic [ITER_BITS-1:0]    iterations;
	logic                    escaped;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [WORD_BITS-1:0]    cfg_wdata = '0;

	mandelbrot_escape_time_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.done       (done),
		.iterations (iterations),
		.escaped    (escaped),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	work_t   work_list[$];
	escape_t expected_escapes[$];

	// mirror of the register file
	logic [WORD_BITS-1:0]  view_min_real  = RST_MIN_REAL;
	logic [WORD_BITS-1:0]  view_min_imag  = RST_MIN_IMAG;
	logic [UWORD_BITS-1:0] view_step      = RST_PIXEL_STEP;
	logic [ITER_BITS-1:0]  view_cap       = RST_MAX_ITER;
	logic [UWORD_BITS-1:0] view_radius_sq = RST_RADIUS_SQ;

	int unsigned     inflight, accepted, writes_done, quiet;
	int unsigned     mismatches, results_seen, escapes_seen, views;
	longint unsigned cycle_count, cycle_limit, budget;
	bit              stim_done;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < MAX_REPORTS) begin
			$display("[%0t] MISMATCH: %s", $time, what);
		end
		mismatches++;
	endtask

	function automatic logic signed [ACC_BITS-1:0] scaled_product(input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b, input int sh);
		logic signed [ACC_BITS-1:0] wa, wb;
		wa = $signed(a);
		wb = $signed(b);
		return (wa * wb) >>> sh;
	endfunction

	function automatic escape_t predict_escape(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		escape_t                    r;
		logic [WORD_BITS-1:0]       step, half, c_re, c_im, z_re, z_im, mag_re, mag_im, mag;
		logic [WORD_BITS:0]         mag_sum;
		logic signed [ACC_BITS-1:0] sq_re, sq_im, sq_ri;
		int unsigned                rounds;
		bit                         gone;
		step   = {1'b0, view_step};
		half   = step >> 1;
		c_re   = view_min_real + WORD_BITS'(px) * step + half;
		c_im   = view_min_imag + WORD_BITS'(py) * step + half;
		z_re   = '0;
		z_im   = '0;
		rounds = 0;
		gone   = 1'b0;
		while (!gone && rounds < view_cap) begin
			sq_re   = scaled_product(z_re, z_re, FRAC_BITS);
			sq_im   = scaled_product(z_im, z_im, FRAC_BITS);
			sq_ri   = scaled_product(z_re, z_im, FRAC_BITS - 1);
			// magnitude test never wraps: squares and their sum saturate
			mag_re  = (sq_re[ACC_BITS-1:WORD_BITS] != '0) ? '1 : sq_re[WORD_BITS-1:0];
			mag_im  = (sq_im[ACC_BITS-1:WORD_BITS] != '0) ? '1 : sq_im[WORD_BITS-1:0];
			mag_sum = {1'b0, mag_re} + {1'b0, mag_im};
			mag     = mag_sum[WORD_BITS] ? '1 : mag_sum[WORD_BITS-1:0];
			z_re    = sq_re[WORD_BITS-1:0] - sq_im[WORD_BITS-1:0] + c_re;
			z_im    = sq_ri[WORD_BITS-1:0] + c_im;
			if (mag > {1'b0, view_radius_sq}) begin
				gone = 1'b1;
			end else begin
				rounds++;
			end
		end
		r.px         = px;
		r.py         = py;
		r.iterations = rounds[ITER_BITS-1:0];
		r.escaped    = (rounds < view_cap);
		return r;
	endfunction

	function automatic void load_register(input logic [CFG_IDX_BITS-1:0] index,
			input logic [WORD_BITS-1:0] wdata);
		case (index)
			REG_MIN_REAL:   view_min_real  = wdata;
			REG_MIN_IMAG:   view_min_imag  = wdata;
			REG_PIXEL_STEP: view_step      = wdata[UWORD_BITS-1:0];
			REG_MAX_ITER:   view_cap       = wdata[ITER_BITS-1:0];
			REG_RADIUS_SQ:  view_radius_sq = wdata[UWORD_BITS-1:0];
			default: ;
		endcase
	endfunction

	task automatic add_write(input logic [CFG_IDX_BITS-1:0] index, input logic [WORD_BITS-1:0] wdata);
		work_t w;
		w = '{is_write: 1'b1, index: index, wdata: wdata, px: '0, py: '0};
		work_list = {work_list, w};
		budget += 20;
	endtask

	// rounds: most rounds this pixel can run, for the cycle budget
	task automatic add_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
			input int unsigned rounds);
		work_t w;
		w = '{is_write: 1'b0, index: '0, wdata: '0, px: px, py: py};
		work_list = {work_list, w};
		budget += 12 + 7 * rounds;
	endtask

	task automatic add_view(input logic [WORD_BITS-1:0] re0, input logic [WORD_BITS-1:0] im0,
			input logic [WORD_BITS-1:0] step0, input logic [WORD_BITS-1:0] cap_word,
			input logic [WORD_BITS-1:0] rad0);
		add_write(REG_MIN_REAL, re0);
		add_write(REG_MIN_IMAG, im0);
		add_write(REG_PIXEL_STEP, step0);
		add_write(REG_MAX_ITER, cap_word);
		add_write(REG_RADIUS_SQ, rad0);
		views++;
	endtask

	// driver: one transaction or register write per edge, from the work list
	always @(posedge clk) begin : driver
		work_t head;
		logic  start_n, we_n;
		bit    take_idle;
		start_n = 1'b0;
		we_n    = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				void'(work_list.pop_front());
				inflight++;
				accepted++;
			end
			if (done && inflight != 0) begin
				inflight--;
			end
			quiet     = (inflight == 0) ? quiet + 1 : 0;
			take_idle = ($urandom_range(0, 99) < 22) &&
				!(accepted >= NO_IDLE_FROM && accepted < NO_IDLE_TO);
			if (work_list.size() != 0) begin
				head = work_list[0];
				if (head.is_write) begin
					// registers change only with the core idle
					if (quiet >= SETTLE_CYCLES) begin
						we_n = 1'b1;
						cfg_index <= head.index;
						cfg_wdata <= head.wdata;
						load_register(head.index, head.wdata);
						void'(work_list.pop_front());
						writes_done++;
					end
				end else if (!take_idle) begin
					start_n = 1'b1;
					pixel_x <= head.px;
					pixel_y <= head.py;
				end
			end else if (inflight == 0) begin
				stim_done = 1'b1;
			end
		end
		start  <= start_n;
		cfg_we <= we_n;
	end

	// monitor: check the strobe first, then record this edge's transaction
	always @(posedge clk) begin : monitor
		escape_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_escapes.size() == 0) begin
					flag_mismatch($sformatf("unexpected result iterations=%0d escaped=%0b",
						iterations, escaped));
				end else begin
					want = expected_escapes.pop_front();
					if (iterations !== want.iterations) begin
						flag_mismatch($sformatf("pixel (%0d,%0d) iterations %0d, expected %0d",
							want.px, want.py, iterations, want.iterations));
					end
					if (escaped !== want.escaped) begin
						flag_mismatch($sformatf("pixel (%0d,%0d) escaped %0b, expected %0b",
							want.px, want.py, escaped, want.escaped));
					end
					results_seen++;
					if (want.escaped) begin
						escapes_seen++;
					end
				end
			end
			if (start && !busy) begin
				expected_escapes = {expected_escapes, predict_escape(pixel_x, pixel_y)};
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_escapes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : run
		logic [WORD_BITS-1:0] re0, im0, step0, cap_word, rad0, far;
		int unsigned          kind, cap, bound;

		// reset view: corners, centre of the set
		add_pixel(12'd0, 12'd0, RST_MAX_ITER);
		add_pixel(12'd4095, 12'd4095, RST_MAX_ITER);
		add_pixel(12'd2048, 12'd1024, RST_MAX_ITER);
		add_pixel(12'd4095, 12'd0, RST_MAX_ITER);
		add_pixel(12'd0, 12'd4095, RST_MAX_ITER);
		add_pixel(12'd2047, 12'd1023, RST_MAX_ITER);

		// zero cap; unused indexes must not disturb anything
		add_write(REG_MAX_ITER, 64'd0);
		add_write(REG_SPARE_LO, {$urandom, $urandom});
		add_write(REG_SPARE_HI, {$urandom, $urandom});
		views++;
		add_pixel(12'd2048, 12'd1024, 0);
		add_pixel(12'd4095, 12'd4095, 0);

		// cap of one, upper write bits masked off
		add_write(REG_MAX_ITER, 64'hFFFF_FFFF_FFFF_0001);
		views++;
		add_pixel(12'd2048, 12'd1024, 1);
		add_pixel(12'd0, 12'd0, 1);

		// c = 0 with zero radius: never leaves, runs to the cap
		add_view(64'd0, 64'd0, 64'd0, 64'd16, 64'd0);
		add_pixel(12'd0, 12'd0, 16);
		add_pixel(12'd4095, 12'd4095, 16);

		// extreme registers: coordinates wrap, squares saturate
		add_view(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '1,
			64'h0000_0000_0000_FFFF, '1);
		add_pixel(12'd0, 12'd0, 8);
		add_pixel(12'd4095, 12'd4095, 8);
		add_pixel(12'd1, 12'd1, 8);
		add_pixel(12'd4094, 12'd7, 8);
		add_pixel(12'd2730, 12'd1365, 8);

		// c = 6+6i: each square fits, their sum overflows and saturates
		add_view(6 * Q_ONE, 6 * Q_ONE, 64'd0, 64'd8, '1);
		add_pixel(12'd0, 12'd0, 8);
		add_pixel(12'd4095, 12'd0, 8);
		add_pixel(12'd123, 12'd3000, 8);

		for (int v = 0; v < RANDOM_VIEWS; v++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				// window over the set, short caps
				re0      = -(64'd9 << 56) + (64'($urandom) << 26);
				im0      = -(64'd6 << 56) + (64'($urandom) << 25);
				step0    = 64'($urandom_range(1 << 12, 1 << 15)) << 33;
				cap      = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 160) :
					$urandom_range(1, 40);
				cap_word = 64'(cap);
				rad0     = ($urandom_range(0, 3) == 0) ?
					((64'($urandom_range(0, 31)) << 58) | 64'($urandom)) : (64'd1 << 60);
				bound    = cap;
			end else if (kind < 8) begin
				// all registers random
				re0      = {$urandom, $urandom};
				im0      = {$urandom, $urandom};
				step0    = {$urandom, $urandom};
				cap      = $urandom_range(1, 48);
				cap_word = {$urandom, 16'($urandom), 16'(cap)};
				rad0     = {$urandom, $urandom};
				bound    = cap;
			end else begin
				// |Re c| >= 3 keeps every pixel escaping within a few rounds,
				// so the cap may take any value
				far      = 64'($urandom_range(4 * 1024, 30 * 1024)) << 48;
				re0      = $urandom_range(0, 1) ? far : -far;
				im0      = {$urandom, $urandom};
				step0    = 64'($urandom) << $urandom_range(0, 14);
				cap      = $urandom_range(1, 65535);
				cap_word = {$urandom, 16'($urandom), 16'(cap)};
				rad0     = {$urandom, $urandom};
				bound    = 8;
			end
			add_view(re0, im0, step0, cap_word, rad0);
			for (int p = 0; p < PIXELS_PER_VIEW; p++) begin
				add_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
					(bound < cap) ? bound : cap);
			end
		end
		cycle_limit = 4 * budget + 20000;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		wait (stim_done);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_escapes.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", expected_escapes.size()));
		end

		$display("checked %0d pixel transactions (%0d escaped) under %0d views, %0d writes",
			results_seen, escapes_seen, views, writes_done);
		$display("covered: reset view, zero and unit caps, wrapped and saturated points, random views");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
